[sv/nested_state_interval_stack_unit_assert.svh]
// Assertion macros for the nested state interval stack checker.
`ifndef NESTED_STATE_INTERVAL_STACK_UNIT_ASSERT_SVH
`define NESTED_STATE_INTERVAL_STACK_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define NSIS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define NSIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/nsis_pkg.sv]
// Shared types, constants and codes of the nested state interval stack.
`timescale 1ns / 1ps
package nsis_pkg;

    // Storage depth and derived widths
    localparam int DEPTH   = 64;
    localparam int DEPTH_W = $clog2(DEPTH + 1);
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W   = 7;
    localparam int CMP_W   = (DEPTH_W > LIM_W) ? DEPTH_W : LIM_W;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_DEPTH  = 2'd0;
    localparam logic [1:0] REG_COLLECTION = 2'd1;
    localparam logic [1:0] REG_EVENT_TYPE = 2'd2;

    // Reset value of the depth limit
    localparam logic [LIM_W-1:0] MAX_DEPTH_RST = 7'd64;

    // One stack entry
    typedef struct packed {
        logic [31:0] state;
        logic [63:0] start;
    } nsis_entry_t;

    // Request from the control logic to the entry memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        nsis_entry_t       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } nsis_mem_req_t;

endpackage

[sv/nsis_mem.sv]
// Entry memory for stack levels below the top, with a registered read and write bypass.
`timescale 1ns / 1ps
module nsis_mem
    import nsis_pkg::*;
(
    input  logic          clk,
    input  nsis_mem_req_t req,
    output nsis_entry_t   rd_data
);

    nsis_entry_t mem [DEPTH];
    nsis_entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Prefetch the entry under the top; forward a same-cycle write
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            if (req.we && (req.waddr == req.raddr))
            begin
                rd_data_reg <= req.wdata;
            end
            else
            begin
                rd_data_reg <= mem[req.raddr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/nested_state_interval_stack_unit.sv]
// Top level of the nested state interval stack: control, top entry and result register.
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------------------
//   command  | start / busy         | operation, state_id, timestamp
//   result   | done (strobe)        | status, event_*, depth_after
//   config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One word is taken every cycle; its result shows on done in the cycle after.
// The top entry sits in flops and the entry below it is prefetched from the
// entry memory on every accepted word, so push and pop finish in a single pass.
// busy stays low and cfg_ready stays high; the result side cannot stall.
// Reset empties the stack and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
module nested_state_interval_stack_unit
    import nsis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [31:0] state_id,
    input  logic [63:0] timestamp,
    output logic        done,
    output logic [1:0]  status,
    output logic        event_valid,
    output logic [31:0] event_collection,
    output logic [31:0] event_type,
    output logic [31:0] event_state,
    output logic [63:0] event_start,
    output logic [63:0] event_end,
    output logic [6:0]  depth_after,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    nsis_entry_t        top_reg, top_next;
    logic [LIM_W-1:0]   max_depth_reg;
    logic [31:0]        collection_reg;
    logic [31:0]        event_type_reg;

    logic               done_reg;
    logic [1:0]         status_reg, status_next;
    logic               ev_valid_reg, ev_valid_next;
    logic [31:0]        ev_coll_reg, ev_coll_next;
    logic [31:0]        ev_type_reg, ev_type_next;
    logic [31:0]        ev_state_reg, ev_state_next;
    logic [63:0]        ev_start_reg, ev_start_next;
    logic [63:0]        ev_end_reg, ev_end_next;
    logic [6:0]         depth_out_reg;

    nsis_mem_req_t      mem_req;
    nsis_entry_t        below_top;

    logic               accept;
    logic [CMP_W-1:0]   limit;
    logic               is_full;
    logic               is_empty;

    function automatic logic [ADDR_W-1:0] rd_ptr_of(input logic [DEPTH_W-1:0] level);
        return level[ADDR_W-1:0];
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Clamp the limit to the storage depth and test the stack
    always_comb
    begin
        if (CMP_W'(max_depth_reg) > CMP_W'(DEPTH))
        begin
            limit = CMP_W'(DEPTH);
        end
        else
        begin
            limit = CMP_W'(max_depth_reg);
        end
        is_full  = CMP_W'(depth_reg) >= limit;
        is_empty = depth_reg == '0;
    end

    // Push or pop one word
    always_comb
    begin
        depth_next    = depth_reg;
        top_next      = top_reg;
        status_next   = ST_DONE;
        ev_valid_next = 1'b0;
        ev_coll_next  = '0;
        ev_type_next  = '0;
        ev_state_next = '0;
        ev_start_next = '0;
        ev_end_next   = '0;
        mem_req       = '0;

        if (accept)
        begin
            if (operation == OP_PUSH)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    depth_next     = depth_reg + DEPTH_W'(1);
                    top_next.state = state_id;
                    top_next.start = timestamp;
                    if (!is_empty)
                    begin
                        // Spill old top into memory and report its interval
                        mem_req.we    = 1'b1;
                        mem_req.waddr = rd_ptr_of(depth_reg - DEPTH_W'(1));
                        mem_req.wdata = top_reg;
                        ev_valid_next = 1'b1;
                        ev_coll_next  = collection_reg;
                        ev_type_next  = event_type_reg;
                        ev_state_next = top_reg.state;
                        ev_start_next = top_reg.start;
                        ev_end_next   = timestamp;
                    end
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    // Report top, promote prefetched entry with a fresh start
                    depth_next     = depth_reg - DEPTH_W'(1);
                    top_next.state = below_top.state;
                    top_next.start = timestamp;
                    ev_valid_next  = 1'b1;
                    ev_coll_next   = collection_reg;
                    ev_type_next   = event_type_reg;
                    ev_state_next  = top_reg.state;
                    ev_start_next  = top_reg.start;
                    ev_end_next    = timestamp;
                end
            end
            // Prefetch the entry under the next top
            mem_req.re    = 1'b1;
            mem_req.raddr = rd_ptr_of(depth_next - DEPTH_W'(2));
        end
    end

    nsis_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (below_top)
    );

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= '0;
            done_reg       <= 1'b0;
            max_depth_reg  <= MAX_DEPTH_RST;
            collection_reg <= '0;
            event_type_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
            done_reg  <= accept;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MAX_DEPTH:  max_depth_reg  <= cfg_data[LIM_W-1:0];
                    REG_COLLECTION: collection_reg <= cfg_data;
                    REG_EVENT_TYPE: event_type_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Advance top entry and result word
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (accept)
        begin
            status_reg    <= status_next;
            ev_valid_reg  <= ev_valid_next;
            ev_coll_reg   <= ev_coll_next;
            ev_type_reg   <= ev_type_next;
            ev_state_reg  <= ev_state_next;
            ev_start_reg  <= ev_start_next;
            ev_end_reg    <= ev_end_next;
            depth_out_reg <= 7'(depth_next);
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign event_valid      = ev_valid_reg;
    assign event_collection = ev_coll_reg;
    assign event_type       = ev_type_reg;
    assign event_state      = ev_state_reg;
    assign event_start      = ev_start_reg;
    assign event_end        = ev_end_reg;
    assign depth_after      = depth_out_reg;

endmodule

[sv/nsis_checker.sv]
// Port-level checker for the nested state interval stack, bound to the top level.
`timescale 1ns / 1ps
`include "nested_state_interval_stack_unit_assert.svh"
module nsis_checker
    import nsis_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        operation,
    input logic [63:0] timestamp,
    input logic        done,
    input logic [1:0]  status,
    input logic        event_valid,
    input logic [31:0] event_state,
    input logic [63:0] event_start,
    input logic [63:0] event_end
);

    logic        word_in;
    logic        pop_in;
    logic        refused;
    logic        quiet_ok;
    logic        pop_end_ok;
    logic [63:0] ts_prev;

    // Hold the timestamp of the last cycle
    always_ff @(posedge clk)
    begin
        ts_prev <= timestamp;
    end

    assign word_in    = rst_n && start && !busy;
    assign pop_in     = word_in && (operation == OP_POP);
    assign refused    = done && (status != ST_DONE);
    assign quiet_ok   = (event_state == '0) && (event_start == '0) && (event_end == '0);
    assign pop_end_ok = (status == ST_EMPTY) || (event_valid && (event_end == ts_prev));

    // Every accepted word gives one result in the next cycle
    `NSIS_ASSERT_NEXT(a_result_follows, word_in, done, "missing result")

    // No result without an accepted word
    `NSIS_ASSERT_NEXT(a_no_stray_result, !(start && !busy), !done, "stray result")

    // A refused word carries no event
    `NSIS_ASSERT_SAME(a_refused_no_event, refused, !event_valid, "event on refusal")

    // A word without an event carries zeroed event fields
    `NSIS_ASSERT_SAME(a_quiet_fields, done && !event_valid, quiet_ok, "event fields not zero")

    // A completed pop ends its interval at the pop time
    `NSIS_ASSERT_NEXT(a_pop_end, pop_in, pop_end_ok, "pop interval end wrong")

endmodule

bind nested_state_interval_stack_unit nsis_checker u_nsis_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .timestamp   (timestamp),
    .done        (done),
    .status      (status),
    .event_valid (event_valid),
    .event_state (event_state),
    .event_start (event_start),
    .event_end   (event_end)
);
